FILE: rtl/core/iwc_pkg.sv
`default_nettype none

package iwc_pkg;

    localparam int SPEED_MAX  = 100;
    localparam int SPEED_W    = 7;
    localparam int SPEED_STEP = SPEED_MAX / 4;
    localparam int TIMER_BITS = 16;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_MANUAL_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOME_LEVEL     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_DELAY    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOWEST_WAIT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REQUEST_WINDOW = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IGNITION_OFF   = 3'd5;

    localparam logic [CFG_W-1:0] SWEEP_DELAY_RST    = 16'd25;
    localparam logic [CFG_W-1:0] SLOWEST_WAIT_RST   = 16'd500;
    localparam logic [CFG_W-1:0] REQUEST_WINDOW_RST = 16'd50;
    localparam logic [CFG_W-1:0] IGNITION_OFF_RST   = 16'd50;

    localparam logic [1:0] REQ_NONE   = 2'b00;
    localparam logic [1:0] REQ_FASTER = 2'b01;

    // count down by one, stop at zero
    function automatic logic [TIMER_BITS-1:0] tick_down(input logic [TIMER_BITS-1:0] t);
        return (t != '0) ? t - 1'b1 : '0;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/intermittent_wiper_controller.sv
`default_nettype none
// An accepted word is held in the input register until the result register
// can take it, is then loaded there, and m_* hands it over from that register.
// Throughput: one word per cycle; both stages advance together whenever the
// result register is free or taken.
// Reset (rst_n low, asynchronous): all but the payload registers take their
// documented defaults, speed is zero, the phase is off and both stages are empty.
module intermittent_wiper_controller
    import iwc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // configuration write port
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    // input word: [1:0] request, [2] home_sensor, [3] emergency, [4] ignition_on
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           s_tdata,
    // result word: [0] motor_on, [7:1] speed_level, [9:8] phase
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [15:0]               m_tdata
);

    typedef enum logic [1:0] {
        PH_OFF  = 2'd0,
        PH_OUT  = 2'd1,
        PH_HOME = 2'd2,
        PH_WAIT = 2'd3
    } phase_t;

    // configuration registers
    logic                  manual_mode_reg;
    logic                  home_level_reg;
    logic [CFG_W-1:0]      sweep_delay_reg;
    logic [CFG_W-1:0]      slowest_wait_reg;
    logic [CFG_W-1:0]      request_window_reg;
    logic [CFG_W-1:0]      ignition_off_reg;

    // input stage and result stage
    logic                  in_valid_reg;
    logic [7:0]            in_data_reg;
    logic                  out_valid_reg;
    logic [15:0]           out_data_reg;
    logic [15:0]           out_data_next;
    logic                  advance;

    // controller state
    logic [SPEED_W-1:0]    speed_reg, speed_next;
    logic [SPEED_W-1:0]    speed_prev_reg, speed_prev_next;
    logic                  req_prev_reg;
    phase_t                phase_reg, phase_next;
    logic [TIMER_BITS-1:0] sweep_timer_reg, sweep_timer_next;
    logic [TIMER_BITS-1:0] window_timer_reg, window_timer_next;
    logic [TIMER_BITS-1:0] ign_timer_reg, ign_timer_next;

    // move a word into the result register when it is empty or being taken
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            manual_mode_reg    <= 1'b0;
            home_level_reg     <= 1'b0;
            sweep_delay_reg    <= SWEEP_DELAY_RST;
            slowest_wait_reg   <= SLOWEST_WAIT_RST;
            request_window_reg <= REQUEST_WINDOW_RST;
            ignition_off_reg   <= IGNITION_OFF_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MANUAL_MODE:    manual_mode_reg    <= cfg_wdata[0];
                CFG_HOME_LEVEL:     home_level_reg     <= cfg_wdata[0];
                CFG_SWEEP_DELAY:    sweep_delay_reg    <= cfg_wdata;
                CFG_SLOWEST_WAIT:   slowest_wait_reg   <= cfg_wdata;
                CFG_REQUEST_WINDOW: request_window_reg <= cfg_wdata;
                CFG_IGNITION_OFF:   ignition_off_reg   <= cfg_wdata;
                default:            ;
            endcase
        end
    end

    // Tick update, in the order the controller defines it:
    // request handling, motor decision, sweep sequencer (auto mode), then ignition clear.
    always_comb
    begin
        logic [1:0]            req;
        logic                  sensor;
        logic                  emcy;
        logic                  ign;
        logic                  active;
        logic                  edge_det;
        logic                  drive;
        logic [SPEED_W-1:0]    spd;
        logic [SPEED_W:0]      spd_up;
        logic [TIMER_BITS-1:0] wt;
        logic [TIMER_BITS-1:0] st;
        logic [TIMER_BITS-1:0] st_dn;
        logic [TIMER_BITS-1:0] it_dn;
        logic [TIMER_BITS+1:0] part;
        logic [TIMER_BITS-1:0] wait_ticks;
        phase_t                ph;

        req    = in_data_reg[1:0];
        sensor = in_data_reg[2];
        emcy   = in_data_reg[3];
        ign    = in_data_reg[4];
        active = (req != REQ_NONE);
        edge_det = active && !req_prev_reg;

        spd    = speed_reg;
        spd_up = {1'b0, speed_reg} + (SPEED_W+1)'(SPEED_STEP);
        wt     = window_timer_reg;
        st     = sweep_timer_reg;
        ph     = phase_reg;
        speed_prev_next = speed_prev_reg;
        drive  = 1'b0;
        st_dn  = '0;
        part   = '0;
        wait_ticks = '0;

        if (manual_mode_reg)
        begin
            // toggle between stopped and full speed
            if (edge_det)
                spd = (speed_reg != '0) ? '0 : SPEED_W'(SPEED_MAX);
            drive = (spd != '0);
        end
        else
        begin
            wt = tick_down(window_timer_reg);
            if (edge_det)
            begin
                if (wt != '0)
                begin
                    // step speed within the window, saturate at both ends
                    if (req == REQ_FASTER)
                        spd = (spd_up > (SPEED_W+1)'(SPEED_MAX)) ?
                              SPEED_W'(SPEED_MAX) : spd_up[SPEED_W-1:0];
                    else
                        spd = (speed_reg >= SPEED_W'(SPEED_STEP)) ?
                              speed_reg - SPEED_W'(SPEED_STEP) : '0;
                end
                else
                begin
                    // single sweep on a request outside the window
                    st = sweep_delay_reg;
                    ph = PH_OUT;
                end
                wt = request_window_reg;
            end

            // motor follows the phase entered from request handling
            drive = (ph == PH_OUT) || (ph == PH_HOME);

            // Home pause = slowest * (1 - speed/max). Speed only takes
            // quarter steps, so the scaled part is a shift-and-add.
            if (spd == '0)
                part = '0;
            else if (spd == SPEED_W'(SPEED_STEP))
                part = {2'b00, slowest_wait_reg} >> 2;
            else if (spd == SPEED_W'(2 * SPEED_STEP))
                part = {2'b00, slowest_wait_reg} >> 1;
            else if (spd == SPEED_W'(3 * SPEED_STEP))
                part = ({2'b00, slowest_wait_reg} + {1'b0, slowest_wait_reg, 1'b0}) >> 2;
            else
                part = {2'b00, slowest_wait_reg};
            wait_ticks = slowest_wait_reg - part[TIMER_BITS-1:0];

            st_dn = tick_down(st);
            case (ph)
                PH_OUT:
                begin
                    st = st_dn;
                    if (st_dn == '0 && sensor != home_level_reg)
                    begin
                        st = sweep_delay_reg;
                        ph = PH_HOME;
                    end
                end
                PH_HOME:
                begin
                    st = st_dn;
                    if (st_dn == '0 && sensor == home_level_reg)
                    begin
                        st = wait_ticks;
                        ph = PH_WAIT;
                    end
                end
                PH_WAIT:
                begin
                    if (spd != '0)
                    begin
                        st = st_dn;
                        // restart on timeout or on a speed change
                        if (st_dn == '0 || spd != speed_prev_reg)
                        begin
                            st = sweep_delay_reg;
                            ph = PH_OUT;
                        end
                    end
                    else
                        ph = PH_OFF;
                end
                default:
                begin
                    if (spd != '0)
                    begin
                        st = sweep_delay_reg;
                        ph = PH_OUT;
                    end
                end
            endcase
            speed_prev_next = spd;
        end

        // ignition off long enough: clear speed once, on the step to zero
        it_dn = tick_down(ign_timer_reg);
        ign_timer_next = ign_timer_reg;
        if (!ign)
        begin
            if (ign_timer_reg != '0)
            begin
                ign_timer_next = it_dn;
                if (it_dn == '0)
                    spd = '0;
            end
        end
        else
            ign_timer_next = ignition_off_reg;

        speed_next        = spd;
        phase_next        = ph;
        sweep_timer_next  = st;
        window_timer_next = wt;
        out_data_next     = {6'b0, ph, spd, drive && !emcy};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            speed_reg        <= '0;
            speed_prev_reg   <= '0;
            req_prev_reg     <= 1'b0;
            phase_reg        <= PH_OFF;
            sweep_timer_reg  <= '0;
            window_timer_reg <= REQUEST_WINDOW_RST;
            ign_timer_reg    <= IGNITION_OFF_RST;
        end
        else
        begin
            if (s_tvalid && s_tready)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
            begin
                out_valid_reg    <= 1'b1;
                speed_reg        <= speed_next;
                speed_prev_reg   <= speed_prev_next;
                req_prev_reg     <= (in_data_reg[1:0] != REQ_NONE);
                phase_reg        <= phase_next;
                sweep_timer_reg  <= sweep_timer_next;
                window_timer_reg <= window_timer_next;
                ign_timer_reg    <= ign_timer_next;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers: hold until the stage advances
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_data_reg <= s_tdata;
        if (advance)
            out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire
